>>> hdl/lc3ie_pkg.sv
package lc3ie_pkg;

  localparam int AddrBits = 16;
  localparam int DataW    = 16;
  localparam int MemDepth = 1 << AddrBits;

  localparam logic [AddrBits-1:0] KbsrAddr     = 16'hFE00;
  localparam logic [AddrBits-1:0] KbdrAddr     = 16'hFE02;
  localparam logic [AddrBits-1:0] StartReset   = 16'h3000;
  localparam logic [DataW-1:0]    KbsrReady    = 16'h8000;
  localparam logic [AddrBits-1:0] ClrLastAddr  = {AddrBits{1'b1}};

  localparam logic [7:0] TrapGetc = 8'h20;
  localparam logic [7:0] TrapOut  = 8'h21;
  localparam logic [7:0] TrapIn   = 8'h23;
  localparam logic [7:0] TrapHalt = 8'h25;

  localparam logic [2:0] CcP = 3'b001;
  localparam logic [2:0] CcZ = 3'b010;
  localparam logic [2:0] CcN = 3'b100;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_EXEC  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_WAIT    = 2'd1,
    ST_HALTED  = 2'd2,
    ST_ILLEGAL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_BR   = 4'h0,
    OP_ADD  = 4'h1,
    OP_LD   = 4'h2,
    OP_ST   = 4'h3,
    OP_JSR  = 4'h4,
    OP_AND  = 4'h5,
    OP_LDR  = 4'h6,
    OP_STR  = 4'h7,
    OP_RTI  = 4'h8,
    OP_NOT  = 4'h9,
    OP_LDI  = 4'hA,
    OP_STI  = 4'hB,
    OP_JMP  = 4'hC,
    OP_RES  = 4'hD,
    OP_LEA  = 4'hE,
    OP_TRAP = 4'hF
  } opcode_e;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_START  = 9'b000000100,
    S_DECODE = 9'b000001000,
    S_EXEC   = 9'b000010000,
    S_LOAD1  = 9'b000100000,
    S_LOAD2  = 9'b001000000,
    S_TRAPWB = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_e;

  typedef struct packed {
    logic clr;
    logic accept;
    logic start;
    logic decode;
    logic exec;
    logic load1;
    logic load2;
    logic trap_wb;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    func_e   func;
    logic    halted;
    logic    key_wait;
    opcode_e opcode;
    logic    trap_key;
    logic    out_free;
    logic    clr_last;
  } dp_stat_t;

  function automatic logic [2:0] cc_of(input logic [DataW-1:0] v);
    if (v == '0) begin
      return CcZ;
    end else if (v[DataW-1]) begin
      return CcN;
    end else begin
      return CcP;
    end
  endfunction

endpackage

>>> hdl/lc3_instruction_executor_top.sv
// Each write, read or halted item passes through start and finish; an LDI goes
//   through fetch, decode, execute and two dependent memory reads before finishing.
// Only one item is in flight at a time; the single-port main memory carries each
//   step in turn, and a new item is taken only after the return to idle.
// Reset: asynchronous, active low. PC resets to 0x3000, flags to Z. A clearing
//   pass then zeroes all 65536 memory words, one per cycle.
module lc3_instruction_executor_top import lc3ie_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] mem_address, [31:16] mem_data, [32] key_valid, [40:33] key_code
  input  logic [47:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] next_pc, [31:16] read_data, [32] char_valid, [40:33] char_out,
  // [43:41] flags
  output logic [47:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  status_e             out_status;
  logic [AddrBits-1:0] out_pc;
  logic [DataW-1:0]    out_rdata;
  logic                out_cv;
  logic [7:0]          out_co;
  logic [2:0]          out_flags;

  // start_address is held and read back; reset always restarts at its reset value
  logic [AddrBits-1:0] start_addr_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= StartReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      start_addr_q <= pwdata[AddrBits-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'h0 : {16'h0, start_addr_q};

  lc3ie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  lc3ie_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_func_i        (func_e'(s_axis_tuser)),
    .in_mem_address_i (s_axis_tdata[15:0]),
    .in_mem_data_i    (s_axis_tdata[31:16]),
    .in_key_valid_i   (s_axis_tdata[32]),
    .in_key_code_i    (s_axis_tdata[40:33]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_status_o     (out_status),
    .out_next_pc_o    (out_pc),
    .out_read_data_o  (out_rdata),
    .out_char_valid_o (out_cv),
    .out_char_out_o   (out_co),
    .out_flags_o      (out_flags)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {4'h0, out_flags, out_co, out_cv, out_rdata, out_pc};

endmodule

>>> hdl/lc3ie_ctrl.sv
module lc3ie_ctrl import lc3ie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dp_stat_t stat_i,
  output logic     in_ready_o,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        if (stat_i.func == FUNC_EXEC && !stat_i.halted) state_d = S_DECODE;
        else state_d = S_FINISH;
      end
      S_DECODE: begin
        if (stat_i.key_wait) state_d = S_FINISH;
        else state_d = S_EXEC;
      end
      S_EXEC: begin
        case (stat_i.opcode)
          OP_LD, OP_LDR, OP_LDI, OP_STI: state_d = S_LOAD1;
          OP_TRAP: begin
            if (stat_i.trap_key) state_d = S_TRAPWB;
            else state_d = S_FINISH;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_LOAD1: begin
        if (stat_i.opcode == OP_LDI) state_d = S_LOAD2;
        else state_d = S_FINISH;
      end
      S_LOAD2:  state_d = S_FINISH;
      S_TRAPWB: state_d = S_FINISH;
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.clr     = (state_q == S_CLEAR);
  assign cmd_o.accept  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.start   = (state_q == S_START);
  assign cmd_o.decode  = (state_q == S_DECODE);
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.load1   = (state_q == S_LOAD1);
  assign cmd_o.load2   = (state_q == S_LOAD2);
  assign cmd_o.trap_wb = (state_q == S_TRAPWB);
  assign cmd_o.finish  = (state_q == S_FINISH) && stat_i.out_free;

endmodule

>>> hdl/lc3ie_dp.sv
module lc3ie_dp import lc3ie_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  func_e               in_func_i,
  input  logic [AddrBits-1:0] in_mem_address_i,
  input  logic [DataW-1:0]    in_mem_data_i,
  input  logic                in_key_valid_i,
  input  logic [7:0]          in_key_code_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output status_e             out_status_o,
  output logic [AddrBits-1:0] out_next_pc_o,
  output logic [DataW-1:0]    out_read_data_o,
  output logic                out_char_valid_o,
  output logic [7:0]          out_char_out_o,
  output logic [2:0]          out_flags_o
);

  // latched item
  func_e               func_q;
  logic [AddrBits-1:0] maddr_q;
  logic [DataW-1:0]    mdata_q;
  logic                keyv_q;
  logic [7:0]          key_q;

  // architectural state
  logic [AddrBits-1:0] pc_q;
  logic [2:0]          cc_q;
  logic                halted_q;
  logic [DataW-1:0]    rf_q [8];
  logic [7:0]          rf_vld_q;

  logic [DataW-1:0]    ir_q, ra_q, rb_q;
  status_e             st_q;
  logic                char_v_q;
  logic [7:0]          char_q;

  // main memory and keyboard data shadow
  logic [DataW-1:0]    mem_q [MemDepth];
  logic [DataW-1:0]    mem_rd_q;
  logic                rd_ovr_q;
  logic [DataW-1:0]    rd_ovr_val_q;
  logic                kbdr_sh_q;
  logic [DataW-1:0]    kbdr_q;
  logic [AddrBits-1:0] clr_cnt_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [AddrBits-1:0] out_pc_q;
  logic [DataW-1:0]    out_rdata_q;
  logic                out_cv_q;
  logic [7:0]          out_co_q;
  logic [2:0]          out_flags_q;

  logic [DataW-1:0]    rd_data, key16, kbsr_new, kbdr_new;
  opcode_e             op;
  logic [2:0]          dr, sr1, ins_sr1, ins_rb;
  logic [DataW-1:0]    off9, off6, imm5, off11, pc_off9, ea, alu_b;
  logic                key_wait, trap_key, out_free;

  logic                mem_we, mem_re;
  logic [AddrBits-1:0] mem_wa, mem_ra;
  logic [DataW-1:0]    mem_wd;

  logic                rf_we, rf_setcc;
  logic [2:0]          rf_wa;
  logic [DataW-1:0]    rf_wd;

  assign rd_data  = rd_ovr_q ? rd_ovr_val_q : mem_rd_q;
  assign key16    = {8'h00, key_q};
  assign kbsr_new = keyv_q ? KbsrReady : '0;
  assign kbdr_new = keyv_q ? key16 : '0;

  assign op      = opcode_e'(ir_q[15:12]);
  assign dr      = ir_q[11:9];
  assign sr1     = ir_q[8:6];
  assign off9    = {{7{ir_q[8]}}, ir_q[8:0]};
  assign off6    = {{10{ir_q[5]}}, ir_q[5:0]};
  assign imm5    = {{11{ir_q[4]}}, ir_q[4:0]};
  assign off11   = {{5{ir_q[10]}}, ir_q[10:0]};
  assign pc_off9 = pc_q + off9;
  assign alu_b   = ir_q[5] ? imm5 : rb_q;
  assign ea      = (op == OP_LDR || op == OP_STR) ? (ra_q + off6) : pc_off9;

  // register sources taken straight from the fetched word
  assign ins_sr1 = rd_data[8:6];
  always_comb begin
    case (opcode_e'(rd_data[15:12]))
      OP_ST, OP_STI, OP_STR: ins_rb = rd_data[11:9];
      OP_TRAP:               ins_rb = 3'd0;
      default:               ins_rb = rd_data[2:0];
    endcase
  end

  // GETC and IN stall without a key; a fetch at the status address never does
  assign key_wait = (pc_q != KbsrAddr) && (rd_data[15:12] == OP_TRAP) && !keyv_q &&
                    (rd_data[7:0] == TrapGetc || rd_data[7:0] == TrapIn);
  assign trap_key = (ir_q[7:0] == TrapGetc) || (ir_q[7:0] == TrapIn);
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.func     = func_q;
  assign stat_o.halted   = halted_q;
  assign stat_o.key_wait = key_wait;
  assign stat_o.opcode   = op;
  assign stat_o.trap_key = trap_key;
  assign stat_o.out_free = out_free;
  assign stat_o.clr_last = (clr_cnt_q == ClrLastAddr);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q  <= in_func_i;
      maddr_q <= in_mem_address_i;
      mdata_q <= in_mem_data_i;
      keyv_q  <= in_key_valid_i;
      key_q   <= in_key_code_i;
    end
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = maddr_q;
    mem_wd = mdata_q;
    mem_re = 1'b0;
    mem_ra = pc_q;
    if (cmd_i.clr) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end
    if (cmd_i.start) begin
      case (func_q)
        FUNC_WRITE: mem_we = 1'b1;
        FUNC_READ: begin
          mem_re = 1'b1;
          mem_ra = maddr_q;
        end
        FUNC_EXEC: mem_re = !halted_q;
        default: mem_re = 1'b0;
      endcase
    end
    if (cmd_i.exec) begin
      case (op)
        OP_LD, OP_LDI, OP_LDR, OP_STI: begin
          mem_re = 1'b1;
          mem_ra = ea;
        end
        OP_ST, OP_STR: begin
          mem_we = 1'b1;
          mem_wa = ea;
          mem_wd = rb_q;
        end
        default: mem_re = 1'b0;
      endcase
    end
    if (cmd_i.load1) begin
      case (op)
        OP_LDI: begin
          mem_re = 1'b1;
          mem_ra = rd_data;
        end
        OP_STI: begin
          mem_we = 1'b1;
          mem_wa = rd_data;
          mem_wd = rb_q;
        end
        default: mem_re = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= mem_q[mem_ra];
  end

  // a status read refreshes both keyboard words; keep the data word in a shadow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      kbdr_sh_q    <= 1'b0;
      kbdr_q       <= '0;
      rd_ovr_q     <= 1'b0;
      rd_ovr_val_q <= '0;
    end else begin
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (mem_re) begin
        rd_ovr_q     <= (mem_ra == KbsrAddr) || (mem_ra == KbdrAddr && kbdr_sh_q);
        rd_ovr_val_q <= (mem_ra == KbsrAddr) ? kbsr_new : kbdr_q;
        if (mem_ra == KbsrAddr) begin
          kbdr_sh_q <= 1'b1;
          kbdr_q    <= kbdr_new;
        end
      end
      if (mem_we && mem_wa == KbdrAddr) kbdr_sh_q <= 1'b0;
    end
  end

  // register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_setcc = 1'b0;
    rf_wa    = dr;
    rf_wd    = rd_data;
    if (cmd_i.exec) begin
      case (op)
        OP_ADD: begin
          rf_we = 1'b1; rf_setcc = 1'b1; rf_wd = ra_q + alu_b;
        end
        OP_AND: begin
          rf_we = 1'b1; rf_setcc = 1'b1; rf_wd = ra_q & alu_b;
        end
        OP_NOT: begin
          rf_we = 1'b1; rf_setcc = 1'b1; rf_wd = ~ra_q;
        end
        OP_LEA: begin
          rf_we = 1'b1; rf_setcc = 1'b1; rf_wd = pc_off9;
        end
        OP_JSR, OP_TRAP: begin
          rf_we = 1'b1; rf_wa = 3'd7; rf_wd = pc_q;
        end
        default: rf_we = 1'b0;
      endcase
    end
    if (cmd_i.load1 && (op == OP_LD || op == OP_LDR)) begin
      rf_we = 1'b1; rf_setcc = 1'b1;
    end
    if (cmd_i.load2) begin
      rf_we = 1'b1; rf_setcc = 1'b1;
    end
    if (cmd_i.trap_wb) begin
      rf_we = 1'b1; rf_setcc = 1'b1; rf_wa = 3'd0; rf_wd = key16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_q[rf_wa] <= rf_wd;
    if (cmd_i.decode) begin
      ir_q <= rd_data;
      ra_q <= rf_vld_q[ins_sr1] ? rf_q[ins_sr1] : '0;
      rb_q <= rf_vld_q[ins_rb] ? rf_q[ins_rb] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      pc_q     <= StartReset;
      cc_q     <= CcZ;
      halted_q <= 1'b0;
      st_q     <= ST_OK;
      char_v_q <= 1'b0;
      char_q   <= '0;
    end else begin
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (rf_we && rf_setcc) cc_q <= cc_of(rf_wd);
      if (cmd_i.start) begin
        st_q     <= ST_OK;
        char_v_q <= 1'b0;
        char_q   <= '0;
      end
      if (cmd_i.decode) begin
        if (key_wait) st_q <= ST_WAIT;
        else pc_q <= pc_q + 1'b1;
      end
      if (cmd_i.exec) begin
        case (op)
          OP_BR: begin
            if ((dr & cc_q) != 3'b000) pc_q <= pc_off9;
          end
          OP_JMP: pc_q <= ra_q;
          OP_JSR: pc_q <= ir_q[11] ? (pc_q + off11) : ra_q;
          OP_TRAP: begin
            if (ir_q[7:0] == TrapOut) begin
              char_v_q <= 1'b1;
              char_q   <= rb_q[7:0];
            end else if (ir_q[7:0] == TrapIn) begin
              char_v_q <= 1'b1;
              char_q   <= key_q;
            end else if (ir_q[7:0] == TrapHalt) begin
              halted_q <= 1'b1;
            end
          end
          OP_RTI, OP_RES: begin
            halted_q <= 1'b1;
            st_q     <= ST_ILLEGAL;
          end
          default: st_q <= st_q;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (st_q == ST_ILLEGAL || st_q == ST_WAIT) out_status_q <= st_q;
      else if (halted_q) out_status_q <= ST_HALTED;
      else out_status_q <= ST_OK;
      out_pc_q    <= pc_q;
      out_rdata_q <= (func_q == FUNC_READ) ? rd_data : '0;
      out_cv_q    <= char_v_q;
      out_co_q    <= char_q;
      out_flags_q <= cc_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_next_pc_o    = out_pc_q;
  assign out_read_data_o  = out_rdata_q;
  assign out_char_valid_o = out_cv_q;
  assign out_char_out_o   = out_co_q;
  assign out_flags_o      = out_flags_q;

endmodule

>>> hdl/lc3ie_chk.sv
module lc3ie_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        pready
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transfer taken while busy");

  // no character on a stalled or faulted instruction
  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == 2'd1 || m_axis_tuser == 2'd3) |-> !m_axis_tdata[32])
    else $error("character emitted without execution");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tdata[43:41]))
    else $error("condition code not one-hot");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind lc3_instruction_executor_top lc3ie_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);

>>> tb/tb.sv
module tb import lc3ie_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // One input item: what the core is asked to do this step.
  typedef struct {
    func_e       func;
    logic [15:0] addr;
    logic [15:0] wdata;
    logic        key_valid;
    logic [7:0]  key_code;
  } cpu_item_t;

  // One result item, as the core reports it after the step.
  typedef struct {
    status_e     status;
    logic [15:0] next_pc;
    logic [15:0] read_data;
    logic        char_valid;
    logic [7:0]  char_out;
    logic [2:0]  flags;
  } cpu_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lc3_instruction_executor_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  localparam logic [2:0] StartAddrReg = 3'd0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Architectural shadow of the core: registers, PC, flags, memory, halt.
  // Items are predicted in the order they are queued, which is the order the
  // core takes them, so the expected results are known at queue time.
  // ---------------------------------------------------------------------------
  logic [15:0] arch_mem [0:65535];
  logic [15:0] arch_reg [0:7];
  logic [15:0] arch_pc;
  logic [2:0]  arch_cc;
  logic        arch_halted;
  logic        cur_kv;
  logic [7:0]  cur_kc;
  logic        emit_valid;
  logic [7:0]  emit_char;

  cpu_item_t   stim_q[$];
  cpu_result_t predicted_q[$];
  int          errors;

  function automatic logic [15:0] sext(logic [15:0] v, int bits);
    logic [15:0] m;
    m = 16'(1) << (bits - 1);
    v = v & ((16'(1) << bits) - 16'd1);
    return (v ^ m) - m;
  endfunction

  function automatic void set_flags(logic [15:0] v);
    if (v == '0) begin
      arch_cc = CcZ;
    end else if (v[15]) begin
      arch_cc = CcN;
    end else begin
      arch_cc = CcP;
    end
  endfunction

  // Memory read with the keyboard status side effect.
  function automatic logic [15:0] mem_load(logic [15:0] a);
    if (a == KbsrAddr) begin
      arch_mem[KbsrAddr] = cur_kv ? KbsrReady : 16'h0000;
      arch_mem[KbdrAddr] = cur_kv ? {8'h00, cur_kc} : 16'h0000;
    end
    return arch_mem[a];
  endfunction

  function automatic status_e exec_instr();
    logic [15:0] pc;
    logic [15:0] raw;
    logic [15:0] ins;
    logic [15:0] b;
    logic [15:0] a;
    logic [2:0]  dr;
    logic [2:0]  sr;
    pc  = arch_pc;
    raw = arch_mem[pc];
    // GETC and IN without a key stall the core without fetching
    if (pc != KbsrAddr && opcode_e'(raw[15:12]) == OP_TRAP && !cur_kv &&
        (raw[7:0] == TrapGetc || raw[7:0] == TrapIn)) begin
      return ST_WAIT;
    end
    ins = mem_load(pc);
    pc = pc + 16'd1;
    arch_pc = pc;
    dr = ins[11:9];
    sr = ins[8:6];
    case (opcode_e'(ins[15:12]))
      OP_BR: begin
        if ((ins[11:9] & arch_cc) != 3'd0) arch_pc = pc + sext(ins, 9);
      end
      OP_ADD, OP_AND: begin
        b = ins[5] ? sext(ins, 5) : arch_reg[ins[2:0]];
        arch_reg[dr] = (opcode_e'(ins[15:12]) == OP_ADD) ? arch_reg[sr] + b
                                                         : arch_reg[sr] & b;
        set_flags(arch_reg[dr]);
      end
      OP_NOT: begin
        arch_reg[dr] = ~arch_reg[sr];
        set_flags(arch_reg[dr]);
      end
      OP_JMP: arch_pc = arch_reg[sr];
      OP_JSR: begin
        b = ins[11] ? pc + sext(ins, 11) : arch_reg[sr];
        arch_reg[7] = pc;
        arch_pc = b;
      end
      OP_LD: begin
        arch_reg[dr] = mem_load(pc + sext(ins, 9));
        set_flags(arch_reg[dr]);
      end
      OP_LDI: begin
        a = mem_load(pc + sext(ins, 9));
        arch_reg[dr] = mem_load(a);
        set_flags(arch_reg[dr]);
      end
      OP_LDR: begin
        arch_reg[dr] = mem_load(arch_reg[sr] + sext(ins, 6));
        set_flags(arch_reg[dr]);
      end
      OP_LEA: begin
        arch_reg[dr] = pc + sext(ins, 9);
        set_flags(arch_reg[dr]);
      end
      OP_ST: arch_mem[pc + sext(ins, 9)] = arch_reg[dr];
      OP_STI: begin
        a = mem_load(pc + sext(ins, 9));
        arch_mem[a] = arch_reg[dr];
      end
      OP_STR: arch_mem[arch_reg[sr] + sext(ins, 6)] = arch_reg[dr];
      OP_TRAP: begin
        arch_reg[7] = pc;
        if (ins[7:0] == TrapGetc) begin
          arch_reg[0] = {8'h00, cur_kc};
          set_flags(arch_reg[0]);
        end else if (ins[7:0] == TrapOut) begin
          emit_valid = 1'b1;
          emit_char  = arch_reg[0][7:0];
        end else if (ins[7:0] == TrapIn) begin
          emit_valid = 1'b1;
          emit_char  = cur_kc;
          arch_reg[0] = {8'h00, cur_kc};
          set_flags(arch_reg[0]);
        end else if (ins[7:0] == TrapHalt) begin
          arch_halted = 1'b1;
        end
      end
      default: begin
        arch_halted = 1'b1;
        return ST_ILLEGAL;
      end
    endcase
    return ST_OK;
  endfunction

  function automatic cpu_result_t predict_step(cpu_item_t it);
    cpu_result_t r;
    r.status    = ST_OK;
    r.read_data = '0;
    emit_valid  = 1'b0;
    emit_char   = '0;
    cur_kv      = it.key_valid;
    cur_kc      = it.key_code;
    if (it.func == FUNC_WRITE) begin
      arch_mem[it.addr] = it.wdata;
    end else if (it.func == FUNC_READ) begin
      r.read_data = mem_load(it.addr);
    end else if (it.func == FUNC_EXEC && !arch_halted) begin
      r.status = exec_instr();
    end
    if (arch_halted && r.status != ST_ILLEGAL) r.status = ST_HALTED;
    r.next_pc    = arch_pc;
    r.char_valid = emit_valid;
    r.char_out   = emit_char;
    r.flags      = arch_cc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void push_item(func_e f, logic [15:0] a, logic [15:0] d,
                                    logic kv, logic [7:0] kc);
    cpu_item_t it;
    it.func = f;
    it.addr = a;
    it.wdata = d;
    it.key_valid = kv;
    it.key_code = kc;
    stim_q.push_back(it);
    predicted_q.push_back(predict_step(it));
  endfunction

  // Store an instruction at the current PC, then execute it.
  function automatic void run_instr(logic [15:0] ins, logic kv, logic [7:0] kc);
    push_item(FUNC_WRITE, arch_pc, ins, 1'($urandom), 8'($urandom));
    // a fetch from the keyboard status word must see zero, never RTI
    push_item(FUNC_EXEC, 16'($urandom), 16'($urandom),
              (arch_pc == KbsrAddr) ? 1'b0 : kv, kc);
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    opcode_e     op;
    w = 16'($urandom);
    do begin
      op = opcode_e'($urandom_range(0, 15));
    end while (op == OP_RTI || op == OP_RES);
    w[15:12] = op;
    if (op == OP_TRAP) begin
      case ($urandom_range(0, 5))
        0: w[7:0] = TrapGetc;
        1: w[7:0] = TrapOut;
        2: w[7:0] = TrapIn;
        3: w[7:0] = 8'h22;
        default: w[7:0] = 8'($urandom);
      endcase
      if (w[7:0] == TrapHalt) w[7:0] = TrapOut;
    end
    return w;
  endfunction

  // True when executing what sits at the PC now cannot stop the core.
  function automatic logic pc_is_safe();
    logic [15:0] w;
    if (arch_pc == KbsrAddr) return 1'b0;
    w = arch_mem[arch_pc];
    if (opcode_e'(w[15:12]) inside {OP_RTI, OP_RES}) return 1'b0;
    if (opcode_e'(w[15:12]) == OP_TRAP && w[7:0] == TrapHalt) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void random_items(int n);
    int          k;
    logic [15:0] a;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          if (pc_is_safe()) begin
            push_item(FUNC_EXEC, 16'($urandom), 16'($urandom),
                      ($urandom_range(0, 3) != 0), 8'($urandom));
          end else begin
            run_instr(rand_instr(), 1'b1, 8'($urandom));
            k++;
          end
        end
        3, 4: begin
          a = ($urandom_range(0, 3) == 0) ? KbsrAddr : 16'($urandom);
          push_item(FUNC_READ, a, 16'($urandom), 1'($urandom), 8'($urandom));
        end
        5, 6: begin
          push_item(FUNC_WRITE, 16'($urandom), 16'($urandom), 1'($urandom),
                    8'($urandom));
        end
        7: push_item(FUNC_NONE, 16'($urandom), 16'($urandom), 1'($urandom),
                     8'($urandom));
        default: begin
          run_instr(rand_instr(), ($urandom_range(0, 3) != 0), 8'($urandom));
          k++;
        end
      endcase
      k++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed queued items into the input stream with random gaps.
  // ---------------------------------------------------------------------------
  int send_gap;
  int send_count;

  always @(posedge clk_i) begin
    cpu_item_t   nxt;
    logic        offer;
    logic        done;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      <= 0;
      send_count    <= 0;
    end else begin
      done  = s_axis_tvalid && s_axis_tready;
      offer = s_axis_tvalid && !done;
      if (done) begin
        void'(stim_q.pop_front());
        send_count <= send_count + 1;
        // stretches of back-to-back items alternate with random gaps
        if ((send_count / 64) % 3 == 1 || $urandom_range(0, 5) == 0) begin
          offer = (stim_q.size() != 0);
          send_gap <= 0;
        end else begin
          send_gap <= $urandom_range(1, 5);
        end
      end else if (!s_axis_tvalid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else begin
          offer = (stim_q.size() != 0);
        end
      end
      if (offer) begin
        nxt = stim_q[0];
        s_axis_tdata <= {7'd0, nxt.key_code, nxt.key_valid, nxt.wdata, nxt.addr};
        s_axis_tuser <= nxt.func;
      end
      s_axis_tvalid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results with random stalls and one long hold-off, and
  // compare each transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  int recv_wait;
  int recv_count;

  always @(posedge clk_i) begin
    cpu_result_t exp_r;
    cpu_result_t got;
    int          w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     <= 0;
      recv_count    <= 0;
    end else begin
      w = recv_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = status_e'(m_axis_tuser);
        got.next_pc    = m_axis_tdata[15:0];
        got.read_data  = m_axis_tdata[31:16];
        got.char_valid = m_axis_tdata[32];
        got.char_out   = m_axis_tdata[40:33];
        got.flags      = m_axis_tdata[43:41];
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d pc=%h", $time,
                   got.status, got.next_pc);
          errors++;
        end else begin
          exp_r = predicted_q.pop_front();
          if (got.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
            errors++;
          end
          if (got.next_pc !== exp_r.next_pc) begin
            $display("%0t: next_pc exp %h got %h", $time, exp_r.next_pc, got.next_pc);
            errors++;
          end
          if (got.read_data !== exp_r.read_data) begin
            $display("%0t: read_data exp %h got %h", $time, exp_r.read_data,
                     got.read_data);
            errors++;
          end
          if (got.char_valid !== exp_r.char_valid) begin
            $display("%0t: char_valid exp %b got %b", $time, exp_r.char_valid,
                     got.char_valid);
            errors++;
          end
          if (got.char_out !== exp_r.char_out) begin
            $display("%0t: char_out exp %h got %h", $time, exp_r.char_out,
                     got.char_out);
            errors++;
          end
          if (got.flags !== exp_r.flags) begin
            $display("%0t: flags exp %b got %b", $time, exp_r.flags, got.flags);
            errors++;
          end
        end
        recv_count <= recv_count + 1;
        // hold off long enough once for the core to back up its input
        if (recv_count == 150) begin
          w = 400;
        end else if ((recv_count / 50) % 4 == 2) begin
          w = 0;
        end else begin
          w = $urandom_range(0, 5);
        end
      end
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        recv_wait <= w - 1;
      end else begin
        m_axis_tready <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  task automatic drain();
    while (stim_q.size() != 0 || predicted_q.size() != 0) @(posedge clk_i);
    // cover the longest instruction after the last transfer
    repeat (12) @(posedge clk_i);
  endtask

  // Write the start address register and read it back.
  task automatic cfg_start_addr(logic [15:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= StartAddrReg;
    pwdata  <= {16'd0, v};
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {16'd0, v}) begin
      $display("%0t: start_address readback exp %h got %h", $time, {16'd0, v},
               prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] stopper;
    errors  = 0;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    for (int i = 0; i < 65536; i++) arch_mem[i] = '0;
    for (int i = 0; i < 8; i++) arch_reg[i] = '0;
    arch_pc     = StartReset;
    arch_cc     = CcZ;
    arch_halted = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every opcode except RTI and RES, immediate extremes, key wait and keyboard reads.
    push_item(FUNC_READ, KbsrAddr, 16'h0, 1'b0, 8'h00);
    push_item(FUNC_READ, KbsrAddr, 16'h0, 1'b1, 8'hFF);
    push_item(FUNC_READ, KbdrAddr, 16'h0, 1'b0, 8'h00);
    push_item(FUNC_WRITE, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00);
    push_item(FUNC_READ, 16'hFFFF, 16'h0, 1'b0, 8'h00);
    push_item(FUNC_NONE, 16'h0, 16'h0, 1'b0, 8'h00);
    run_instr({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10}, 1'b0, 8'h00);
    run_instr({OP_ADD, 3'd2, 3'd1, 1'b1, 5'h0F}, 1'b0, 8'h00);
    run_instr({OP_ADD, 3'd3, 3'd1, 1'b0, 2'b00, 3'd2}, 1'b0, 8'h00);
    run_instr({OP_AND, 3'd4, 3'd1, 1'b0, 2'b00, 3'd3}, 1'b0, 8'h00);
    run_instr({OP_NOT, 3'd5, 3'd4, 6'h3F}, 1'b0, 8'h00);
    run_instr({OP_LEA, 3'd6, 9'h0FF}, 1'b0, 8'h00);
    run_instr({OP_ST, 3'd5, 9'h100}, 1'b0, 8'h00);
    run_instr({OP_LD, 3'd0, 9'h0FF}, 1'b0, 8'h00);
    run_instr({OP_STR, 3'd3, 3'd6, 6'h20}, 1'b0, 8'h00);
    run_instr({OP_LDR, 3'd2, 3'd6, 6'h1F}, 1'b0, 8'h00);
    run_instr({OP_STI, 3'd1, 9'h1FE}, 1'b0, 8'h00);
    run_instr({OP_LDI, 3'd7, 9'h1FD}, 1'b0, 8'h00);
    run_instr({OP_TRAP, 4'h0, TrapGetc}, 1'b0, 8'h41);  // waits for a key
    push_item(FUNC_EXEC, 16'h0, 16'h0, 1'b1, 8'h80);
    run_instr({OP_TRAP, 4'h0, TrapIn}, 1'b1, 8'hFF);
    run_instr({OP_TRAP, 4'h0, TrapOut}, 1'b1, 8'h00);
    run_instr({OP_TRAP, 4'h0, 8'h22}, 1'b0, 8'h00);
    run_instr({OP_BR, 3'b111, 9'h100}, 1'b0, 8'h00);
    run_instr({OP_JSR, 1'b1, 11'h400}, 1'b0, 8'h00);
    run_instr({OP_JSR, 1'b0, 2'b00, 3'd6, 6'h00}, 1'b0, 8'h00);
    run_instr({OP_JMP, 3'd0, 3'd7, 6'h00}, 1'b0, 8'h00);
    drain();

    // Random phases, separated by start address writes, two of them at the extremes.
    cfg_start_addr(16'h0000);
    random_items(220);
    drain();
    cfg_start_addr(16'hFFFF);
    random_items(220);
    drain();
    cfg_start_addr(16'($urandom));
    random_items(220);
    drain();
    cfg_start_addr(StartReset);
    random_items(200);

    // Stop the core at the very end; nothing can restart it without reset.
    case ($urandom_range(0, 2))
      0: stopper = {OP_TRAP, 4'h0, TrapHalt};
      1: stopper = {OP_RTI, 12'($urandom)};
      default: stopper = {OP_RES, 12'($urandom)};
    endcase
    run_instr(stopper, 1'b1, 8'($urandom));
    push_item(FUNC_EXEC, 16'h0, 16'h0, 1'b1, 8'h00);
    push_item(FUNC_WRITE, 16'h1234, 16'hBEEF, 1'b0, 8'h00);
    push_item(FUNC_READ, 16'h1234, 16'h0, 1'b0, 8'h00);
    push_item(FUNC_NONE, 16'h0, 16'h0, 1'b0, 8'h00);
    push_item(FUNC_EXEC, 16'h0, 16'h0, 1'b0, 8'h00);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Clearing pass plus ~1000 slow items with stalls, several times over.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
